// ----- src/ski_pkg.sv -----
// Package for the spline key interpolator: item types, opcodes and the
// cubic basis coefficient rows. No dependencies.
`default_nettype none

package ski_pkg;

  // Opcodes
  localparam logic [1:0] OP_LINEAR  = 2'd0;
  localparam logic [1:0] OP_HERMITE = 2'd1;
  localparam logic [1:0] OP_BEZIER  = 2'd2;

  // Q1.16 one
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Rounding shifts: weight Q.48 -> Q2.29, sum Q.45 -> Q16.16
  localparam int WEIGHT_SHIFT = 19;
  localparam int SUM_SHIFT    = 29;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [16:0]        ratio;
    logic signed [31:0] start_value;
    logic signed [31:0] start_tangent;
    logic signed [31:0] end_tangent;
    logic signed [31:0] end_value;
    logic               last_component;
  } in_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic               last_out;
  } out_t;

  // One basis polynomial: c0*t^3 + c1*t^2 + c2*t + c3
  typedef struct packed {
    logic signed [3:0] c0;
    logic signed [3:0] c1;
    logic signed [3:0] c2;
    logic signed [3:0] c3;
  } coef_row_t;

  // Rows per operand lane: start value, start tangent, end tangent, end value
  localparam coef_row_t HERMITE_ROWS [4] = '{
    '{4'sd2,  -4'sd3, 4'sd0, 4'sd1},
    '{4'sd1,  -4'sd2, 4'sd1, 4'sd0},
    '{4'sd1,  -4'sd1, 4'sd0, 4'sd0},
    '{-4'sd2, 4'sd3,  4'sd0, 4'sd0}
  };

  localparam coef_row_t BEZIER_ROWS [4] = '{
    '{-4'sd1, 4'sd3,  -4'sd3, 4'sd1},
    '{4'sd3,  -4'sd6, 4'sd3,  4'sd0},
    '{-4'sd3, 4'sd3,  4'sd0,  4'sd0},
    '{4'sd1,  4'sd0,  4'sd0,  4'sd0}
  };

  // Linear as a degenerate cubic: (1 - t) on start value, t on end value
  localparam coef_row_t LINEAR_ROWS [4] = '{
    '{4'sd0, 4'sd0, -4'sd1, 4'sd1},
    '{4'sd0, 4'sd0, 4'sd0,  4'sd0},
    '{4'sd0, 4'sd0, 4'sd0,  4'sd0},
    '{4'sd0, 4'sd0, 4'sd1,  4'sd0}
  };

  // Coefficient row for one lane; the unused opcode runs as linear
  function automatic coef_row_t sel_row(input logic [1:0] op, input logic [1:0] lane);
    coef_row_t row;
    case (op)
      OP_HERMITE: row = HERMITE_ROWS[lane];
      OP_BEZIER:  row = BEZIER_ROWS[lane];
      default:    row = LINEAR_ROWS[lane];
    endcase
    return row;
  endfunction

endpackage

`default_nettype wire

// ----- src/spline_key_interpolator.sv -----
// Spline key interpolator top level: six-stage pipeline of Horner weight
// evaluation, weighted products and a rounded, saturated sum. Uses ski_pkg.
`default_nettype none

// One item is accepted per cycle (start high while busy is low) and its
// result appears on out_item with the out_valid strobe once it has passed
// the six register stages, for one cycle only; the receiver cannot hold
// results off, so it must take every strobe. The stages are three Horner
// steps per basis weight, the operand-weight multiply, and a two-level add
// tree with rounding and saturation. busy is high only during reset and
// the cycle after it; otherwise the block takes a transfer every cycle.
module spline_key_interpolator
  import ski_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_item,
  output logic      out_valid,
  output out_t      out_item
);

  // Control: valid bit per stage
  logic       busy_r;
  logic [5:0] vld_r;
  logic       take;

  assign take = start && !busy_r;
  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[4:0], take};
    end
  end

  assign out_valid = vld_r[5];

  // Stage 1: clamp ratio, first Horner step
  logic [16:0]        t_c;
  logic signed [17:0] t_s0;
  coef_row_t          row;
  logic signed [20:0] h1_nxt [4];
  logic signed [3:0]  c2_nxt [4];
  logic signed [3:0]  c3_nxt [4];
  logic signed [31:0] val_nxt [4];

  always_comb begin
    t_c  = (in_item.ratio > ONE_Q16) ? ONE_Q16 : in_item.ratio;
    t_s0 = $signed({1'b0, t_c});
    val_nxt[0] = in_item.start_value;
    val_nxt[1] = in_item.start_tangent;
    val_nxt[2] = in_item.end_tangent;
    val_nxt[3] = in_item.end_value;
    row = '0;
    for (int i = 0; i < 4; i++) begin
      row       = sel_row(in_item.opcode, 2'(i));
      h1_nxt[i] = 21'(row.c0) * 21'(t_s0) + (21'(row.c1) <<< 16);
      c2_nxt[i] = row.c2;
      c3_nxt[i] = row.c3;
    end
  end

  logic [16:0]        t1_r, t2_r;
  logic signed [20:0] h1_r [4];
  logic signed [3:0]  c2_r [4];
  logic signed [3:0]  c3a_r [4];
  logic signed [3:0]  c3b_r [4];
  logic signed [31:0] v1_r [4];
  logic signed [31:0] v2_r [4];
  logic signed [31:0] v3_r [4];
  logic [4:0]         last_r;

  // Stage 2 and 3: remaining Horner steps, then round weight to Q2.29
  logic signed [36:0] h2_nxt [4];
  logic signed [36:0] h2_r [4];
  logic signed [53:0] h3_nxt [4];
  logic signed [31:0] w_nxt [4];
  logic signed [31:0] w_r [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      h2_nxt[i] = 37'(h1_r[i]) * 37'($signed({1'b0, t1_r})) + (37'(c2_r[i]) <<< 32);
      h3_nxt[i] = 54'(h2_r[i]) * 54'($signed({1'b0, t2_r})) + (54'(c3b_r[i]) <<< 48);
      w_nxt[i]  = 32'((h3_nxt[i] + (54'sd1 <<< (WEIGHT_SHIFT - 1))) >>> WEIGHT_SHIFT);
    end
  end

  // Stage 4: operand times weight
  logic signed [63:0] p_nxt [4];
  logic signed [63:0] p_r [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      p_nxt[i] = 64'(v3_r[i]) * 64'(w_r[i]);
    end
  end

  // Stage 5: pair sums
  logic signed [64:0] s01_nxt, s23_nxt, s01_r, s23_r;

  assign s01_nxt = 65'(p_r[0]) + 65'(p_r[1]);
  assign s23_nxt = 65'(p_r[2]) + 65'(p_r[3]);

  // Stage 6: total, round to Q16.16, saturate
  logic signed [65:0] tot;
  logic signed [65:0] shr;
  out_t               out_nxt;
  out_t               out_r;

  always_comb begin
    tot = 66'(s01_r) + 66'(s23_r) + (66'sd1 <<< (SUM_SHIFT - 1));
    shr = tot >>> SUM_SHIFT;
    if (shr > 66'sh7FFFFFFF) begin
      out_nxt.interp_value = 32'sh7FFFFFFF;
    end else if (shr < -66'sh80000000) begin
      out_nxt.interp_value = 32'sh80000000;
    end else begin
      out_nxt.interp_value = 32'(shr);
    end
    out_nxt.last_out = last_r[4];
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    t1_r   <= t_c;
    t2_r   <= t1_r;
    last_r <= {last_r[3:0], in_item.last_component};
    for (int i = 0; i < 4; i++) begin
      h1_r[i]  <= h1_nxt[i];
      c2_r[i]  <= c2_nxt[i];
      c3a_r[i] <= c3_nxt[i];
      c3b_r[i] <= c3a_r[i];
      v1_r[i]  <= val_nxt[i];
      v2_r[i]  <= v1_r[i];
      v3_r[i]  <= v2_r[i];
      h2_r[i]  <= h2_nxt[i];
      w_r[i]   <= w_nxt[i];
      p_r[i]   <= p_nxt[i];
    end
    s01_r <= s01_nxt;
    s23_r <= s23_nxt;
    out_r <= out_nxt;
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

// ----- verif/ski_result_checker.sv -----
// Result checker for spline_key_interpolator: watches the command and result
// channels, predicts each interpolated value and compares. Uses ski_pkg.
`default_nettype none

module ski_result_checker
  import ski_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic busy,
  input  wire in_t  in_item,
  input  wire logic out_valid,
  input  wire out_t out_item,
  output int        mismatches,
  output int        outstanding
);

  localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
  localparam logic signed [79:0] SAT_LO = -80'sd2147483648;

  // Interpolated values still owed by the block, oldest first
  out_t expected_results[$];

  // Basis polynomial for one operand lane, packed as four signed nibbles c0..c3
  function automatic logic [15:0] basis_row(input logic [1:0] op, input logic [1:0] lane);
    logic [15:0] row;
    row = '0;
    if (op == OP_HERMITE) begin
      case (lane)
        2'd0: row = {4'sd2, -4'sd3, 4'sd0, 4'sd1};
        2'd1: row = {4'sd1, -4'sd2, 4'sd1, 4'sd0};
        2'd2: row = {4'sd1, -4'sd1, 4'sd0, 4'sd0};
        default: row = {-4'sd2, 4'sd3, 4'sd0, 4'sd0};
      endcase
    end else begin
      case (lane)
        2'd0: row = {-4'sd1, 4'sd3, -4'sd3, 4'sd1};
        2'd1: row = {4'sd3, -4'sd6, 4'sd3, 4'sd0};
        2'd2: row = {-4'sd3, 4'sd3, 4'sd0, 4'sd0};
        default: row = {4'sd1, 4'sd0, 4'sd0, 4'sd0};
      endcase
    end
    return row;
  endfunction

  // Exact Horner evaluation in Q.48, rounded to a Q2.29 weight
  function automatic logic signed [79:0] basis_weight(input logic [15:0] row,
                                                      input logic signed [79:0] t);
    logic signed [79:0] acc;
    logic signed [79:0] c1;
    logic signed [79:0] c2;
    logic signed [79:0] c3;
    acc = $signed(row[15:12]);
    c1  = $signed(row[11:8]);
    c2  = $signed(row[7:4]);
    c3  = $signed(row[3:0]);
    acc = acc * t + (c1 <<< 16);
    acc = acc * t + (c2 <<< 32);
    acc = acc * t + (c3 <<< 48);
    return (acc + (80'sd1 <<< 18)) >>> 19;
  endfunction

  // Expected result of one key pair
  function automatic out_t interpolate_key(input in_t key);
    logic signed [79:0] t;
    logic signed [79:0] acc;
    logic signed [79:0] res;
    logic signed [79:0] opnd [4];
    out_t result;
    // ratio above one clamps to one
    t = (key.ratio > ONE_Q16) ? ONE_Q16 : key.ratio;
    opnd[0] = $signed(key.start_value);
    opnd[1] = $signed(key.start_tangent);
    opnd[2] = $signed(key.end_tangent);
    opnd[3] = $signed(key.end_value);
    if (key.opcode == OP_HERMITE || key.opcode == OP_BEZIER) begin
      acc = '0;
      for (int lane = 0; lane < 4; lane++) begin
        acc = acc + opnd[lane] * basis_weight(basis_row(key.opcode, 2'(lane)), t);
      end
      res = (acc + (80'sd1 <<< 28)) >>> 29;
    end else begin
      // linear, spare opcode too; tangents play no part
      acc = opnd[0] * (80'sd65536 - t) + opnd[3] * t;
      res = (acc + (80'sd1 <<< 15)) >>> 16;
    end
    if (res > SAT_HI) res = SAT_HI;
    if (res < SAT_LO) res = SAT_LO;
    result.interp_value = res[31:0];
    result.last_out     = key.last_component;
    return result;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Retire a result transfer, then queue the prediction for a command transfer
  always @(posedge clk) begin : watch_edge
    out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual value %h last %b",
                   $time, out_item.interp_value, out_item.last_out);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.interp_value !== want.interp_value) begin
            $display("%0t: interp_value mismatch: expected %h, actual %h",
                     $time, want.interp_value, out_item.interp_value);
            mismatches++;
          end
          if (out_item.last_out !== want.last_out) begin
            $display("%0t: last_out mismatch: expected %b, actual %b",
                     $time, want.last_out, out_item.last_out);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(interpolate_key(in_item));
      end
    end
    outstanding = expected_results.size();
  end

endmodule

`default_nettype wire

// ----- verif/tb_spline_key_interpolator.sv -----
// Testbench top for spline_key_interpolator: directed and random key pairs,
// sender gaps in three phases. Uses ski_pkg and ski_result_checker.
`default_nettype none

module tb_spline_key_interpolator;
  import ski_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int PHASE_ITEMS  = 600;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic out_valid;
  in_t  in_item;
  out_t out_item;
  int   gap_pct;
  int   mismatches;
  int   outstanding;

  always #6 clk = ~clk;

  spline_key_interpolator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  ski_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Watchdog
  initial begin
    #2000000;
    $display("** spline_key_interpolator: FAILED **");
    $finish;
  end

  function automatic in_t make_key(input logic [1:0] op, input logic [16:0] ratio,
                                   input logic [31:0] p0, input logic [31:0] t0,
                                   input logic [31:0] t1, input logic [31:0] p1,
                                   input logic last);
    in_t key;
    key.opcode         = op;
    key.ratio          = ratio;
    key.start_value    = p0;
    key.start_tangent  = t0;
    key.end_tangent    = t1;
    key.end_value      = p1;
    key.last_component = last;
    return key;
  endfunction

  // Mostly modest animation values, with full-range words and both bounds
  function automatic logic [31:0] rand_q16();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2, 3: v = $urandom;
      default: begin
        v = $urandom_range(0, 24'hFF_FFFF);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [16:0] rand_ratio();
    logic [16:0] r;
    case ($urandom_range(0, 19))
      0: r = '0;
      1: r = ONE_Q16;
      2: r = 17'($urandom);
      3: r = 17'($urandom_range(65537, 131071));
      default: r = 17'($urandom_range(0, 65536));
    endcase
    return r;
  endfunction

  function automatic logic [1:0] rand_op();
    logic [1:0] op;
    case ($urandom_range(0, 9))
      0, 1, 2: op = OP_LINEAR;
      3, 4, 5: op = OP_HERMITE;
      6, 7, 8: op = OP_BEZIER;
      default: op = OP_SPARE;
    endcase
    return op;
  endfunction

  // One command transfer, after a random gap; start stays high until taken
  task automatic send_key(input in_t key);
    logic took;
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    took = 1'b0;
    while (!took) begin
      start   <= 1'b1;
      in_item <= key;
      took    = !busy;
      @(negedge clk);
    end
  endtask

  // Vectors of three channels mostly sharing opcode and ratio, with some broken marks
  task automatic send_vectors(input int count);
    logic [1:0]  op;
    logic [16:0] ratio;
    logic        last;
    op = OP_LINEAR;
    ratio = '0;
    for (int n = 0; n < count; n++) begin
      if (n % 3 == 0 || $urandom_range(0, 19) == 0) begin
        op    = rand_op();
        ratio = rand_ratio();
      end
      last = (n % 3 == 2);
      if ($urandom_range(0, 9) == 0) last = ~last;
      send_key(make_key(op, ratio, rand_q16(), rand_q16(), rand_q16(), rand_q16(), last));
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    gap_pct = 10;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ratio ends, clamping, bounds, spare opcode, saturation
    send_key(make_key(OP_LINEAR, 17'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000, 1'b0));
    send_key(make_key(OP_LINEAR, ONE_Q16, 32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000, 1'b0));
    send_key(make_key(OP_LINEAR, 17'd32768, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000,
                      1'b1));
    send_key(make_key(OP_LINEAR, 17'd65535, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF,
                      1'b0));
    send_key(make_key(OP_LINEAR, 17'h1FFFF, 32'h0003_8000, 32'h0, 32'h0, 32'hFFFE_0001,
                      1'b0));
    send_key(make_key(OP_LINEAR, 17'd21845, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'hFFFF_FFFF, 1'b1));
    send_key(make_key(OP_SPARE, 17'd16384, 32'h0010_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'hFFF0_0000, 1'b0));
    send_key(make_key(OP_SPARE, 17'h1FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0,
                      32'h7FFF_FFFF, 1'b1));
    send_key(make_key(OP_HERMITE, 17'd0, 32'h0005_0000, 32'h0001_0000, 32'hFFFF_0000,
                      32'h0009_0000, 1'b0));
    send_key(make_key(OP_HERMITE, ONE_Q16, 32'h0005_0000, 32'h0001_0000, 32'hFFFF_0000,
                      32'h0009_0000, 1'b0));
    send_key(make_key(OP_HERMITE, 17'd32768, 32'hFFFB_8000, 32'h0002_0000, 32'h0003_0000,
                      32'h000A_0000, 1'b1));
    // Hermite overflow toward both bounds
    send_key(make_key(OP_HERMITE, 17'd20000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 1'b0));
    send_key(make_key(OP_HERMITE, 17'd45000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 1'b0));
    send_key(make_key(OP_HERMITE, 17'h1FFFF, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F,
                      32'hF0F0_F0F0, 1'b1));
    send_key(make_key(OP_BEZIER, 17'd32768, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 1'b0));
    send_key(make_key(OP_BEZIER, 17'd32768, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 1'b0));
    send_key(make_key(OP_BEZIER, 17'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 1'b1));
    send_key(make_key(OP_BEZIER, 17'd65535, 32'h0000_0000, 32'h0100_0000, 32'hFF00_0000,
                      32'h0040_0000, 1'b0));
    send_key(make_key(OP_BEZIER, 17'd70000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h3333_3333,
                      32'hCCCC_CCCC, 1'b1));
    send_key(make_key(OP_BEZIER, 17'd0, 32'hDEAD_BEEF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h0000_0001, 1'b0));
    send_key(make_key(OP_LINEAR, 17'd1, 32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000, 1'b1));

    // Random vectors: light sender gaps, heavy gaps, then back to back
    send_vectors(PHASE_ITEMS);
    gap_pct = 80;
    send_vectors(PHASE_ITEMS);
    gap_pct = 0;
    send_vectors(PHASE_ITEMS);
    start <= 1'b0;

    // Drain the pipeline
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("** spline_key_interpolator: PASSED **");
    end else begin
      $display("** spline_key_interpolator: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
